FILE: rtl/core/rdas_pkg.sv
// Shared types, character codes and digit helpers for the radix digit adder/subtractor.
`default_nettype none
package rdas_pkg;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [6:0] OUT_ZERO  = 7'h30;
	localparam logic [6:0] OUT_ONE   = 7'h31;
	localparam logic [6:0] OUT_UP_A  = 7'h41;
	localparam logic [5:0] DEC_TEN   = 6'd10;
	localparam logic [5:0] DIGIT_BAD = 6'd36;
	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;
	localparam logic [5:0] RADIX_RST = 6'd10;
	localparam logic [8:0] COUNT_FIELD_MAX = 9'd511;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_SUB = 1'b1;

	// Decoded digit pair handed from front to back.
	typedef struct packed {
		logic       action;
		logic [5:0] radix;
		logic [5:0] d1;
		logic [5:0] d2;
		logic       bad;
		logic       final_pair;
	} pair_t;

	// One result word.
	typedef struct packed {
		logic [6:0] digit_char;
		logic       is_last;
		logic [8:0] digit_count;
		logic       bad_digit;
		logic       borrow_out;
	} result_t;

	// Value 0..35, or DIGIT_BAD when the character is not a digit.
	function automatic logic [5:0] decode_char(input logic [7:0] ch);
		logic [5:0] v;
		if (ch inside {[CH_ZERO:CH_NINE]}) begin
			v = 6'(ch - CH_ZERO);
		end else if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
			v = 6'(ch - CH_UP_A) + DEC_TEN;
		end else if (ch inside {[CH_LOW_A:CH_LOW_Z]}) begin
			v = 6'(ch - CH_LOW_A) + DEC_TEN;
		end else begin
			v = DIGIT_BAD;
		end
		return v;
	endfunction

	function automatic logic [6:0] encode_digit(input logic [5:0] v);
		logic [6:0] c;
		if (v < DEC_TEN) begin
			c = OUT_ZERO + {1'b0, v};
		end else begin
			c = OUT_UP_A + {1'b0, v - DEC_TEN};
		end
		return c;
	endfunction

	function automatic logic [5:0] clamp_radix(input logic [5:0] r);
		logic [5:0] v;
		if (r < RADIX_MIN) begin
			v = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			v = RADIX_MAX;
		end else begin
			v = r;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/radix_digit_add_subtract.sv
// Top level of the digit-serial radix adder/subtractor.
//
// Input channel: one word per digit pair, least significant first. A word
// is taken at a clock edge with push high and full low. Each pair carries
// action (add or subtract second from first), both ASCII digits and
// final_pair on the most significant pair.
// Result channel: queue style. While empty is low the oldest result word
// sits on the result ports; pop with empty low takes it.
// Configuration: cfg_write loads cfg_data into the radix register at once;
// write only while the block is idle.
// A pair passes the pair queue and the back end into the result queue.
// Throughput: one pair per cycle while the result queue has room; the final
// pair of an addition that carries out holds the next pair for a carry word.
// A two-word pair queue decouples decoding from the carry loop, and a
// result queue of QUEUE_DEPTH words absorbs receiver stalls; when it fills,
// the back end stops, the pair queue fills and full rises.
// Reset: queues empty, carry and counts zero, radix 10.
`default_nettype none
module radix_digit_add_subtract #(
	parameter int MAX_DIGITS  = 256,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [5:0] cfg_data,
	input  wire logic       push,
	output logic            full,
	input  wire logic       action,
	input  wire logic [7:0] first_char,
	input  wire logic [7:0] second_char,
	input  wire logic       final_pair,
	output logic            empty,
	input  wire logic       pop,
	output logic [6:0]      digit_char,
	output logic            is_last,
	output logic [8:0]      digit_count,
	output logic            bad_digit,
	output logic            borrow_out
);
	import rdas_pkg::*;

	localparam int PAIR_DEPTH = 2;

	logic [5:0] radix_q;
	pair_t      fe_data, be_data;
	logic       fe_push, pq_full, pq_empty, be_pop;
	result_t    res_in, res_out;
	logic       res_push, rq_full;
	logic [$bits(pair_t)-1:0]   pq_rdata;
	logic [$bits(result_t)-1:0] rq_rdata;

	// Radix register: hold until written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RST;
		end else if (cfg_write) begin
			radix_q <= cfg_data;
		end
	end

	rdas_front u_front (
		.push        (push),
		.full        (full),
		.action      (action),
		.first_char  (first_char),
		.second_char (second_char),
		.final_pair  (final_pair),
		.radix       (radix_q),
		.q_push      (fe_push),
		.q_data      (fe_data),
		.q_full      (pq_full)
	);

	// Decoded pairs waiting for the carry loop.
	rdas_queue #(.WIDTH($bits(pair_t)), .DEPTH(PAIR_DEPTH)) u_pair_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_data),
		.full   (pq_full),
		.pop    (be_pop),
		.rdata  (pq_rdata),
		.empty  (pq_empty)
	);

	assign be_data = pair_t'(pq_rdata);

	rdas_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (pq_empty),
		.q_data   (be_data),
		.q_pop    (be_pop),
		.out_full (rq_full),
		.out_push (res_push),
		.out_data (res_in)
	);

	// Result words waiting for the receiver.
	rdas_queue #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign res_out     = result_t'(rq_rdata);
	assign digit_char  = res_out.digit_char;
	assign is_last     = res_out.is_last;
	assign digit_count = res_out.digit_count;
	assign bad_digit   = res_out.bad_digit;
	assign borrow_out  = res_out.borrow_out;

endmodule
`default_nettype wire

FILE: rtl/core/rdas_queue.sv
// Small register queue with first-word fall-through read.
`default_nettype none
module rdas_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	// DEPTH must be a power of two so that the pointers wrap by themselves.
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW:0] FULL_CNT = (AW+1)'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rdas_front.sv
// Front end: decode and classify each incoming character pair.
`default_nettype none
module rdas_front (
	input  wire logic          push,
	output logic               full,
	input  wire logic          action,
	input  wire logic [7:0]    first_char,
	input  wire logic [7:0]    second_char,
	input  wire logic          final_pair,
	input  wire logic [5:0]    radix,
	output logic               q_push,
	output rdas_pkg::pair_t    q_data,
	input  wire logic          q_full
);
	import rdas_pkg::*;

	logic [5:0] r, raw1, raw2;
	logic       bad1, bad2;

	always_comb begin
		r    = clamp_radix(radix);
		raw1 = decode_char(first_char);
		raw2 = decode_char(second_char);
		// Undecodable chars decode to 36, which is never below the radix.
		bad1 = (raw1 >= r);
		bad2 = (raw2 >= r);
		q_data.action     = action;
		q_data.radix      = r;
		q_data.d1         = bad1 ? '0 : raw1;
		q_data.d2         = bad2 ? '0 : raw2;
		q_data.bad        = bad1 || bad2;
		q_data.final_pair = final_pair;
	end

	assign full   = q_full;
	assign q_push = push;

endmodule
`default_nettype wire

FILE: rtl/core/rdas_back.sv
// Back end: carry/borrow arithmetic, digit counts and result word generation.
`default_nettype none
module rdas_back #(
	parameter int MAX_DIGITS = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_empty,
	input  wire rdas_pkg::pair_t q_data,
	output logic                 q_pop,
	input  wire logic            out_full,
	output logic                 out_push,
	output rdas_pkg::result_t    out_data
);
	import rdas_pkg::*;

	localparam int CAP = (MAX_DIGITS < int'(COUNT_FIELD_MAX)) ? MAX_DIGITS
		: int'(COUNT_FIELD_MAX);
	localparam logic [8:0] CAP_CNT = 9'(CAP);

	function automatic logic [8:0] sat_inc(input logic [8:0] v);
		logic [9:0] s;
		s = {1'b0, v} + 10'd1;
		return (s > {1'b0, CAP_CNT}) ? CAP_CNT : s[8:0];
	endfunction

	logic       carry_q;
	logic [8:0] pos_q, top_q;
	logic       extra_q;
	logic [8:0] extra_cnt_q;

	logic [8:0] pos_n, top_n;
	logic [6:0] sum, sub;
	logic [5:0] digit;
	logic       carry_n;
	logic       take;

	assign take = !extra_q && !q_empty && !out_full;

	always_comb begin
		pos_n   = sat_inc(pos_q);
		sum     = 7'(q_data.d1) + 7'(q_data.d2) + 7'(carry_q);
		sub     = 7'(q_data.d2) + 7'(carry_q);
		digit   = '0;
		carry_n = 1'b0;
		if (q_data.action == ACT_ADD) begin
			if (sum >= 7'(q_data.radix)) begin
				digit   = 6'(sum - 7'(q_data.radix));
				carry_n = 1'b1;
			end else begin
				digit = sum[5:0];
			end
		end else begin
			if (7'(q_data.d1) < sub) begin
				digit   = 6'(7'(q_data.d1) + 7'(q_data.radix) - sub);
				carry_n = 1'b1;
			end else begin
				digit = 6'(7'(q_data.d1) - sub);
			end
		end
		top_n = (digit != '0) ? pos_n : top_q;

		out_data.digit_char  = encode_digit(digit);
		out_data.is_last     = 1'b0;
		out_data.digit_count = '0;
		out_data.bad_digit   = q_data.bad;
		out_data.borrow_out  = 1'b0;
		if (extra_q) begin
			out_data.digit_char  = OUT_ONE;
			out_data.is_last     = 1'b1;
			out_data.digit_count = extra_cnt_q;
			out_data.bad_digit   = 1'b0;
		end else if (q_data.final_pair) begin
			if (q_data.action == ACT_ADD) begin
				if (!carry_n) begin
					out_data.is_last     = 1'b1;
					out_data.digit_count = pos_n;
				end
			end else begin
				out_data.is_last     = 1'b1;
				out_data.digit_count = (top_n == '0) ? 9'd1 : top_n;
				out_data.borrow_out  = carry_n;
			end
		end
	end

	assign q_pop    = take;
	assign out_push = (extra_q && !out_full) || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q     <= 1'b0;
			pos_q       <= '0;
			top_q       <= '0;
			extra_q     <= 1'b0;
			extra_cnt_q <= '0;
		end else begin
			if (extra_q && !out_full) begin
				extra_q <= 1'b0;
			end
			if (take) begin
				if (q_data.final_pair) begin
					carry_q <= 1'b0;
					pos_q   <= '0;
					top_q   <= '0;
					// Hold the carry digit for one more word.
					if (q_data.action == ACT_ADD && carry_n) begin
						extra_q     <= 1'b1;
						extra_cnt_q <= sat_inc(pos_n);
					end
				end else begin
					carry_q <= carry_n;
					pos_q   <= pos_n;
					top_q   <= top_n;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_on_extra: assert property (@(posedge clk) disable iff (!arst_n)
		extra_q |-> !q_pop)
		else $error("pair taken while carry digit pending");
	a_pop_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> out_push)
		else $error("pair taken without a result word");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result word pushed into full queue");
	a_extra_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(extra_q) |-> (pos_q == '0 && carry_q == 1'b0))
		else $error("state not cleared at end of number");
`endif

endmodule
`default_nettype wire
